// ===== hdl/faiq_pkg.sv =====
// ----------------------------------------------------------------------------
// faiq_pkg
// Shared types and constants of the fire alarm input qualifier: request and
// result payloads, configuration registers, lamp codes.
// ----------------------------------------------------------------------------
package faiq_pkg;

  localparam int unsigned FloorCount  = 3;
  localparam int unsigned SourceCount = 10;
  localparam int unsigned LatchW      = 11;
  localparam int unsigned StopBit     = 10;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;

  localparam logic [7:0] HoldReset = 8'd5;
  localparam logic [7:0] LinkReset = 8'd35;

  // Register index, taken from byte address bit 2
  typedef enum logic {
    RegHoldTicks = 1'b0,
    RegLinkLimit = 1'b1
  } faiq_reg_e;

  // Button lamp codes
  localparam logic [1:0] ButtonNone = 2'd0;
  localparam logic [1:0] ButtonOne  = 2'd1;
  localparam logic [1:0] ButtonBoth = 2'd2;

  // Confirm lamp codes
  localparam logic [1:0] ConfirmOff    = 2'd0;
  localparam logic [1:0] ConfirmBlink  = 2'd1;
  localparam logic [1:0] ConfirmSteady = 2'd2;

  typedef struct packed {
    logic [5:0] button_pairs;
    logic [2:0] enable_requests;
    logic [2:0] smoke_requests;
    logic       general_request;
    logic       stop_request;
    logic       second_tick;
    logic [7:0] net_count;
  } faiq_req_t;

  typedef struct packed {
    logic [10:0] fire_latches;
    logic [2:0]  floor_status;
    logic [1:0]  button_lamp_1;
    logic [1:0]  button_lamp_2;
    logic [1:0]  button_lamp_3;
    logic [1:0]  confirm_lamp_1;
    logic [1:0]  confirm_lamp_2;
    logic [1:0]  confirm_lamp_3;
    logic        link_lamp;
    logic        ready_phase;
  } faiq_rsp_t;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [7:0] link_limit;
  } faiq_cfg_t;

  // Lamp code for one floor's button pair
  function automatic logic [1:0] button_code(input logic [1:0] pair);
    logic [1:0] code;
    unique case (pair)
      2'b00:   code = ButtonNone;
      2'b11:   code = ButtonBoth;
      default: code = ButtonOne;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/faiq_regs.sv =====
// ----------------------------------------------------------------------------
// faiq_regs
// Configuration register file behind an APB-style port: hold time and link
// error limit.
// ----------------------------------------------------------------------------
module faiq_regs
  import faiq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready,
  output faiq_cfg_t               cfg_o
);

  faiq_cfg_t cfg_q;
  faiq_reg_e reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = faiq_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks <= HoldReset;
      cfg_q.link_limit <= LinkReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegHoldTicks: cfg_q.hold_ticks <= pwdata[7:0];
        RegLinkLimit: cfg_q.link_limit <= pwdata[7:0];
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      RegHoldTicks: prdata = {{(DataW-8){1'b0}}, cfg_q.hold_ticks};
      RegLinkLimit: prdata = {{(DataW-8){1'b0}}, cfg_q.link_limit};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/faiq_qual.sv =====
// ----------------------------------------------------------------------------
// faiq_qual
// Qualifier state and one-pass update logic: ten hold counters, fire
// latches, stop hold-off, floor status and blink phase, plus lamp decode.
// ----------------------------------------------------------------------------
module faiq_qual
  import faiq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  faiq_req_t req_i,
  input  faiq_cfg_t cfg_i,
  output faiq_rsp_t rsp_o
);

  logic [7:0]        cnt_q [SourceCount];
  logic [7:0]        cnt_d [SourceCount];
  logic [7:0]        stop_cnt_q, stop_cnt_d;
  logic [LatchW-1:0] latch_q, latch_d;
  logic [2:0]        status_q, status_d;
  logic              blink_q, blink_d;
  logic [SourceCount-1:0] cond;

  // Gather the source conditions
  always_comb begin
    for (int f = 0; f < FloorCount; f++) begin
      cond[f] = &req_i.button_pairs[2*f +: 2];
    end
    cond[5:3] = req_i.enable_requests;
    cond[8:6] = req_i.smoke_requests;
    cond[9]   = req_i.general_request;
  end

  // Next state for one request
  always_comb begin
    cnt_d      = cnt_q;
    stop_cnt_d = stop_cnt_q;
    latch_d    = latch_q;
    status_d   = status_q;
    priority if (req_i.stop_request) begin
      // Stop: keep only the stop latch
      latch_d          = '0;
      latch_d[StopBit] = 1'b1;
    end else if (latch_q[StopBit]) begin
      if (stop_cnt_q != 8'd0) begin
        // Hold-off: count down, suppress floor status
        if (req_i.second_tick) stop_cnt_d = stop_cnt_q - 8'd1;
        latch_d          = '0;
        latch_d[StopBit] = 1'b1;
        status_d         = '0;
      end else begin
        // Hold-off done: drop the stop latch
        latch_d[StopBit] = 1'b0;
      end
    end else begin
      // Normal: qualify every source
      stop_cnt_d = cfg_i.hold_ticks;
      for (int i = 0; i < SourceCount; i++) begin
        if (cond[i]) begin
          if (cnt_q[i] != 8'd0) begin
            if (req_i.second_tick) cnt_d[i] = cnt_q[i] - 8'd1;
          end else begin
            latch_d[i] = 1'b1;
          end
        end else begin
          cnt_d[i] = cfg_i.hold_ticks;
        end
      end
      status_d = latch_d[2:0];
    end
    blink_d = blink_q ^ req_i.second_tick;
  end

  // Hold state, advance on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SourceCount; i++) cnt_q[i] <= '0;
      stop_cnt_q <= '0;
      latch_q    <= '0;
      status_q   <= '0;
      blink_q    <= 1'b0;
    end else if (advance_i) begin
      cnt_q      <= cnt_d;
      stop_cnt_q <= stop_cnt_d;
      latch_q    <= latch_d;
      status_q   <= status_d;
      blink_q    <= blink_d;
    end
  end

  // Decode lamps from buttons and updated latches
  function automatic logic [1:0] confirm_code(input logic en_latch, input logic btn_latch);
    logic [1:0] code;
    priority if (en_latch) code = ConfirmSteady;
    else if (btn_latch)    code = ConfirmBlink;
    else                   code = ConfirmOff;
    return code;
  endfunction

  always_comb begin
    rsp_o.fire_latches   = latch_d;
    rsp_o.floor_status   = status_d;
    rsp_o.button_lamp_1  = button_code(req_i.button_pairs[1:0]);
    rsp_o.button_lamp_2  = button_code(req_i.button_pairs[3:2]);
    rsp_o.button_lamp_3  = button_code(req_i.button_pairs[5:4]);
    rsp_o.confirm_lamp_1 = confirm_code(latch_d[3], latch_d[0]);
    rsp_o.confirm_lamp_2 = confirm_code(latch_d[4], latch_d[1]);
    rsp_o.confirm_lamp_3 = confirm_code(latch_d[5], latch_d[2]);
    rsp_o.link_lamp      = (req_i.net_count >= cfg_i.link_limit);
    rsp_o.ready_phase    = blink_d;
  end

endmodule

// ===== hdl/fire_alarm_input_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// fire_alarm_input_qualifier_core
// The accepting edge loads the input register; the result register loads after
// one pass of qualifier logic, once the result slot is free or draining.
// Throughput: one request per cycle (single-pass update) while not stalled.
// Reset: asynchronous, active low; clears counters, latches, status, blink
// phase and both valid flags; registers return to hold 5 and link limit 35.
// ----------------------------------------------------------------------------
module fire_alarm_input_qualifier_core
  import faiq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  faiq_req_t        in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output faiq_rsp_t        out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  faiq_cfg_t cfg;
  faiq_req_t in_q;
  logic      in_valid_q;
  faiq_rsp_t out_q, rsp;
  logic      out_valid_q;
  logic      advance;
  logic      load_in;

  faiq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a request forward when the result slot is free or draining
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign load_in    = in_valid_i & ~in_stall_o;

  faiq_qual u_qual (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (in_q),
    .cfg_i     (cfg),
    .rsp_o     (rsp)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) in_q <= in_req_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Stall only when a request waits behind a blocked result
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked request");

  // An advanced request always lands in the result register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request did not produce a result");

  // A taken result with nothing behind it empties the slot
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !advance) |=> !out_valid_q)
    else $error("result repeated after being taken");

  // A stop request leaves only the stop latch set
  a_stop_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.stop_request) |=>
      (out_q.fire_latches == (LatchW'(1) << StopBit)))
    else $error("stop request did not clear the latches");

endmodule

// ===== tb/sv/fire_alarm_input_qualifier_checker.sv =====
// ----------------------------------------------------------------------------
// fire_alarm_input_qualifier_checker
// Watches the request, result and register channels of the fire alarm input
// qualifier, predicts every panel result from the accepted polls and compares
// the results in order, field by field. Hands the mismatch count and the
// number of outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module fire_alarm_input_qualifier_checker
  import faiq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  faiq_req_t        in_req_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  faiq_rsp_t        out_rsp_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int               error_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintCap = 40;
  localparam logic [LatchW-1:0] StopOnly = LatchW'(1 << StopBit);

  // Predictor copy of configuration and state
  logic [7:0]          hold_cfg;
  logic [7:0]          link_cfg;
  logic [7:0]          source_left [SourceCount];
  logic [7:0]          holdoff_left;
  logic [LatchW-1:0]   latch_q;
  logic [FloorCount-1:0] status_q;
  logic                blink_q;
  faiq_rsp_t           panel_q [$];
  int unsigned         result_no;

  task automatic report_mismatch(input string what);
    error_count_o++;
    if (error_count_o <= PrintCap) $display("MISMATCH %s", what);
  endtask

  task automatic check_field(input string name, input logic [LatchW-1:0] got,
                             input logic [LatchW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_no, name, got, want));
  endtask

  // Advance the predicted panel by one poll and build its result
  task automatic predict_panel(input faiq_req_t poll, output faiq_rsp_t rsp);
    logic [SourceCount-1:0] held;
    logic [1:0]             pair;
    logic [1:0]             button_lamp [FloorCount];
    logic [1:0]             confirm_lamp [FloorCount];
    for (int f = 0; f < FloorCount; f++) held[f] = &poll.button_pairs[2*f +: 2];
    held[5:3] = poll.enable_requests;
    held[8:6] = poll.smoke_requests;
    held[9]   = poll.general_request;

    if (poll.stop_request) begin
      latch_q = StopOnly;
    end else if (latch_q[StopBit]) begin
      // hold the floor status at zero until the hold-off runs out
      if (holdoff_left != 8'd0) begin
        if (poll.second_tick) holdoff_left = holdoff_left - 8'd1;
        latch_q  = StopOnly;
        status_q = '0;
      end else begin
        latch_q[StopBit] = 1'b0;
      end
    end else begin
      holdoff_left = hold_cfg;
      for (int i = 0; i < SourceCount; i++) begin
        if (!held[i]) begin
          source_left[i] = hold_cfg;
        end else if (source_left[i] != 8'd0) begin
          if (poll.second_tick) source_left[i] = source_left[i] - 8'd1;
        end else begin
          latch_q[i] = 1'b1;
        end
      end
      status_q = latch_q[FloorCount-1:0];
    end

    if (poll.second_tick) blink_q = ~blink_q;

    // Derive lamp codes from the buttons and the updated latches
    for (int f = 0; f < FloorCount; f++) begin
      pair = poll.button_pairs[2*f +: 2];
      if (pair == 2'b11) button_lamp[f] = ButtonBoth;
      else if (pair == 2'b00) button_lamp[f] = ButtonNone;
      else button_lamp[f] = ButtonOne;
      if (latch_q[3+f]) confirm_lamp[f] = ConfirmSteady;
      else if (latch_q[f]) confirm_lamp[f] = ConfirmBlink;
      else confirm_lamp[f] = ConfirmOff;
    end

    rsp.fire_latches   = latch_q;
    rsp.floor_status   = status_q;
    rsp.button_lamp_1  = button_lamp[0];
    rsp.button_lamp_2  = button_lamp[1];
    rsp.button_lamp_3  = button_lamp[2];
    rsp.confirm_lamp_1 = confirm_lamp[0];
    rsp.confirm_lamp_2 = confirm_lamp[1];
    rsp.confirm_lamp_3 = confirm_lamp[2];
    rsp.link_lamp      = (poll.net_count >= link_cfg);
    rsp.ready_phase    = blink_q;
  endtask

  task automatic compare_panel(input faiq_rsp_t got, input faiq_rsp_t want);
    check_field("fire_latches", got.fire_latches, want.fire_latches);
    check_field("floor_status", got.floor_status, want.floor_status);
    check_field("button_lamp_1", got.button_lamp_1, want.button_lamp_1);
    check_field("button_lamp_2", got.button_lamp_2, want.button_lamp_2);
    check_field("button_lamp_3", got.button_lamp_3, want.button_lamp_3);
    check_field("confirm_lamp_1", got.confirm_lamp_1, want.confirm_lamp_1);
    check_field("confirm_lamp_2", got.confirm_lamp_2, want.confirm_lamp_2);
    check_field("confirm_lamp_3", got.confirm_lamp_3, want.confirm_lamp_3);
    check_field("link_lamp", got.link_lamp, want.link_lamp);
    check_field("ready_phase", got.ready_phase, want.ready_phase);
  endtask

  // Track register writes, predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    faiq_rsp_t want;
    if (!rst_ni) begin
      hold_cfg      = HoldReset;
      link_cfg      = LinkReset;
      for (int i = 0; i < SourceCount; i++) source_left[i] = 8'd0;
      holdoff_left  = 8'd0;
      latch_q       = '0;
      status_q      = '0;
      blink_q       = 1'b0;
      panel_q.delete();
      result_no     = 0;
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (faiq_reg_e'(paddr[2]))
          RegHoldTicks: hold_cfg = pwdata[7:0];
          RegLinkLimit: link_cfg = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_panel(in_req_i, want);
        panel_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (panel_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending",
                                    result_no));
        end else begin
          want = panel_q.pop_front();
          compare_panel(out_rsp_i, want);
        end
        result_no++;
      end
      pending_o = panel_q.size();
    end
  end

endmodule

// ===== tb/sv/fire_alarm_input_qualifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// fire_alarm_input_qualifier_core_tb
// Drives polls into the fire alarm input qualifier: a directed run through
// latching, stop and hold-off, then phases of mostly steady alarm scenes with
// random ticks, stops and link counts under several register settings and
// idle and stall mixes. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fire_alarm_input_qualifier_core_tb;
  import faiq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int          ReqW        = $bits(faiq_req_t);

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  faiq_req_t        in_req;
  logic             out_valid;
  logic             out_stall;
  faiq_rsp_t        out_rsp;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int          errors;
  int          pending;
  int unsigned cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_off_left = 0;

  // Alarm scene: buttons [5:0], enables [8:6], smoke [11:9], general [12]
  logic [12:0] scene;
  int          stop_run;
  logic [7:0]  link_now;

  fire_alarm_input_qualifier_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  fire_alarm_input_qualifier_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_rsp_i     (out_rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic write_reg(input faiq_reg_e idx, input logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = DataW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == RegLinkLimit) link_now = value;
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic offer_poll(input faiq_req_t poll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req   = poll;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [5:0] buttons, input logic [2:0] enables,
                             input logic [2:0] smoke, input logic general,
                             input logic stop, input logic tick,
                             input logic [7:0] net);
    faiq_req_t poll;
    poll.button_pairs    = buttons;
    poll.enable_requests = enables;
    poll.smoke_requests  = smoke;
    poll.general_request = general;
    poll.stop_request    = stop;
    poll.second_tick     = tick;
    poll.net_count       = net;
    offer_poll(poll);
  endtask

  // Mostly a slowly changing alarm scene with short stop bursts; some noise
  task automatic next_random_poll(output faiq_req_t poll);
    if ($urandom_range(99) < 12) begin
      poll = faiq_req_t'(ReqW'($urandom));
      if ($urandom_range(3) != 0) poll.stop_request = 1'b0;
    end else begin
      if ($urandom_range(99) < 5) scene = 13'($urandom);
      else if ($urandom_range(99) < 20) scene = scene ^ (13'(1) << $urandom_range(12));
      poll.button_pairs    = scene[5:0];
      poll.enable_requests = scene[8:6];
      poll.smoke_requests  = scene[11:9];
      poll.general_request = scene[12];
      if (stop_run > 0) begin
        poll.stop_request = 1'b1;
        stop_run--;
      end else if ($urandom_range(99) < 3) begin
        poll.stop_request = 1'b1;
        stop_run = $urandom_range(3);
      end else begin
        poll.stop_request = 1'b0;
      end
      poll.second_tick = ($urandom_range(99) < 45);
      poll.net_count   = ($urandom_range(3) == 0) ?
                         link_now + 8'($urandom_range(2)) - 8'd1 : 8'($urandom);
    end
  endtask

  // Drop valid and wait until every result is out and the pipe is empty
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] hold, input logic [7:0] limit,
                           input int idle, input int stall, input int hold_off,
                           input int count);
    faiq_req_t poll;
    wait_idle();
    write_reg(RegHoldTicks, hold);
    write_reg(RegLinkLimit, limit);
    send_idle_pct = idle;
    stall_pct     = stall;
    hold_off_left = hold_off;
    repeat (count) begin
      next_random_poll(poll);
      offer_poll(poll);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    scene    = '0;
    stop_run = 0;
    link_now = LinkReset;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: every source held at the first poll latches at once,
    // then a quiet poll
    send_fields(6'h3F, 3'b111, 3'b111, 1'b1, 1'b0, 1'b1, 8'd0);
    send_fields(6'h00, 3'b000, 3'b000, 1'b0, 1'b0, 1'b0, 8'd0);
    // One button, alternating buttons, link lamp around the limit
    send_fields(6'h01, 3'b000, 3'b000, 1'b0, 1'b0, 1'b0, 8'd34);
    send_fields(6'h2A, 3'b000, 3'b000, 1'b0, 1'b0, 1'b0, 8'd35);
    send_fields(6'h3F, 3'b111, 3'b111, 1'b1, 1'b0, 1'b0, 8'd255);
    // Stop request clears every latch but the stop latch, held over two polls
    send_fields(6'h3F, 3'b111, 3'b111, 1'b1, 1'b1, 1'b0, 8'hF0);
    send_fields(6'h00, 3'b000, 3'b000, 1'b0, 1'b1, 1'b1, 8'hF0);
    // Stop released: hold-off runs out, then floors 0 and 1 count down and latch
    repeat (7) send_fields(6'h0F, 3'b010, 3'b000, 1'b0, 1'b0, 1'b1, 8'd10);
    repeat (6) send_fields(6'h0F, 3'b010, 3'b000, 1'b0, 1'b0, 1'b1, 8'd10);
    send_fields(6'h00, 3'b000, 3'b000, 1'b0, 1'b0, 1'b0, 8'd0);

    // Random phases over register settings and idle mixes
    run_phase(8'd0,   8'd0,   0,  0,  300, 400);
    run_phase(8'd2,   8'd255, 76, 0,  0,   350);
    run_phase(8'd255, 8'd128, 0,  76, 0,   250);
    run_phase(8'd3,   8'd35,  10, 10, 0,   450);
    run_phase(8'd1,   8'd200, 0,  0,  0,   450);

    // Drain with a bound, then give the verdict
    in_valid  = 1'b0;
    stall_pct = 0;
    for (int k = 0; k < 2000 && pending != 0; k++) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/faiq_pkg.sv
hdl/faiq_regs.sv
hdl/faiq_qual.sv
hdl/fire_alarm_input_qualifier_core.sv
tb/sv/fire_alarm_input_qualifier_checker.sv
tb/sv/fire_alarm_input_qualifier_core_tb.sv
